### hdl/rtcp_rr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RTCP receiver report statistics block.
package rtcp_rr_pkg;

   localparam int SOURCES_DEF = 32;
   localparam int SLOT_W      = 5;

   // Restoring divider: one quotient bit per step over a 32-bit dividend.
   localparam int DIV_STEPS = 32;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [23:0] CUM_MAX  = 24'h7fffff;
   localparam logic [23:0] CUM_MIN  = 24'h800000;
   localparam logic [28:0] LSUM_MAX = {1'b0, {28{1'b1}}};
   localparam logic [28:0] LSUM_MIN = {1'b1, {28{1'b0}}};
   localparam logic [36:0] RSUM_MAX = {37{1'b1}};

   typedef struct packed {
      logic capture;
      logic read;
      logic calc1;
      logic calc2;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

### hdl/rtcp_rr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing table read, arithmetic, division and result load.
module rtcp_rr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rtcp_rr_pkg::status_type status,
   output rtcp_rr_pkg::cmd_type    cmd
);
   import rtcp_rr_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_CALC1 = 6'b000100,
      ST_CALC2 = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CALC1;
         end
         ST_CALC1: begin
            cmd.calc1 = 1'b1;
            state_in  = ST_CALC2;
         end
         ST_CALC2: begin
            cmd.calc2 = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result load while output register is occupied");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transfer accepted while an item is in work");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_LAST) |=> (state_ff == ST_DONE))
      else $error("divider did not end after its last step");

endmodule

### hdl/rtcp_rr_dp.sv
`timescale 1ns / 1ps
// Datapath: prior-count tables, interval arithmetic, loss divider, running totals, result register.
module rtcp_rr_dp #(
   parameter int SOURCES = rtcp_rr_pkg::SOURCES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rtcp_rr_pkg::cmd_type            cmd,
   output rtcp_rr_pkg::status_type         status,
   input  logic [rtcp_rr_pkg::SLOT_W-1:0]  req_slot,
   input  logic                            req_start_of_report,
   input  logic [31:0]                     req_source_id,
   input  logic [31:0]                     req_seq_cycles,
   input  logic [15:0]                     req_max_seq,
   input  logic [15:0]                     req_base_seq,
   input  logic [31:0]                     req_received_count,
   input  logic [31:0]                     req_jitter_in,
   input  logic [31:0]                     req_sr_ntp_seconds,
   input  logic [31:0]                     req_sr_ntp_fraction,
   input  logic                            req_sr_seen,
   input  logic [31:0]                     req_delay_since_sr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_included,
   output logic [31:0]                     rsp_ssrc_out,
   output logic [7:0]                      rsp_fraction_lost,
   output logic signed [23:0]              rsp_cumulative_lost,
   output logic [31:0]                     rsp_highest_seq_ext,
   output logic [31:0]                     rsp_jitter_out,
   output logic [31:0]                     rsp_last_sr,
   output logic [31:0]                     rsp_delay_last_sr,
   output logic signed [28:0]              rsp_total_lost,
   output logic [36:0]                     rsp_total_received
);
   import rtcp_rr_pkg::*;

   localparam int IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int SLOTS = 2 ** SLOT_W;

   // Fold every possible slot number onto the table once, at elaboration.
   function automatic logic [SLOTS*IDX_W-1:0] fold_slots();
      logic [SLOTS*IDX_W-1:0] fold;
      fold = '0;
      for (int i = 0; i < SLOTS; i++) begin
         fold[i*IDX_W +: IDX_W] = IDX_W'(i % SOURCES);
      end
      return fold;
   endfunction

   localparam logic [SLOTS*IDX_W-1:0] SLOT_FOLD = fold_slots();

   // captured item
   logic [IDX_W-1:0] idx_ff;
   logic             sor_ff;
   logic [31:0]      ssrc_ff, cycles_ff, recv_ff, jit_ff, dly_ff;
   logic [15:0]      maxs_ff, bases_ff;
   logic [31:0]      last_sr_ff;
   logic             seen_ff;

   // prior-count tables with per-entry valid bits (empty entry reads as zero)
   logic [31:0]        mem_exp [SOURCES];
   logic [31:0]        mem_rcv [SOURCES];
   logic [SOURCES-1:0] vld_ff;
   logic [31:0]        rd_exp_ff, rd_rcv_ff;
   logic               rd_vld_ff;
   logic [31:0]        prior_exp, prior_rcv;

   // arithmetic stages
   logic [31:0] expected_ff, rcv_int_ff, exp_int, lost_int, cum_diff;
   logic        include_ff, frac_ok_ff;
   logic [23:0] cum_ff, cum_in;

   // divider
   logic [31:0] divisor_ff, rem_ff, quo_ff;
   logic [32:0] trial;

   // running totals
   logic signed [28:0] lost_sum_ff, lost_base, lost_sat;
   logic [36:0]        rcv_sum_ff, rcv_base, rcv_sat;
   logic [29:0]        lost_wide;
   logic [37:0]        rcv_wide;

   logic rsp_valid_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;

   assign prior_exp = rd_vld_ff ? rd_exp_ff : '0;
   assign prior_rcv = rd_vld_ff ? rd_rcv_ff : '0;

   assign exp_int  = expected_ff - prior_exp;
   assign lost_int = exp_int - rcv_int_ff;
   assign cum_diff = expected_ff - recv_ff;

   always_comb begin
      if (!cum_diff[31] && (cum_diff[30:23] != 8'h00)) begin
         cum_in = CUM_MAX;
      end else if (cum_diff[31] && (cum_diff[30:23] != 8'hff)) begin
         cum_in = CUM_MIN;
      end else begin
         cum_in = cum_diff[23:0];
      end
   end

   assign trial = {rem_ff, quo_ff[31]} - {1'b0, divisor_ff};

   assign lost_base = sor_ff ? '0 : lost_sum_ff;
   assign rcv_base  = sor_ff ? '0 : rcv_sum_ff;
   assign lost_wide = {lost_base[28], lost_base} + {{6{cum_ff[23]}}, cum_ff};
   assign rcv_wide  = {1'b0, rcv_base} + {6'b0, recv_ff};

   always_comb begin
      if (lost_wide[29] != lost_wide[28]) begin
         lost_sat = lost_wide[29] ? LSUM_MIN : LSUM_MAX;
      end else begin
         lost_sat = lost_wide[28:0];
      end
      rcv_sat = rcv_wide[37] ? RSUM_MAX : rcv_wide[36:0];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff     <= SLOT_FOLD[req_slot * IDX_W +: IDX_W];
         sor_ff     <= req_start_of_report;
         ssrc_ff    <= req_source_id;
         cycles_ff  <= req_seq_cycles;
         maxs_ff    <= req_max_seq;
         bases_ff   <= req_base_seq;
         recv_ff    <= req_received_count;
         jit_ff     <= req_jitter_in;
         last_sr_ff <= {req_sr_ntp_seconds[15:0], req_sr_ntp_fraction[31:16]};
         seen_ff    <= req_sr_seen;
         dly_ff     <= req_delay_since_sr;
      end
      if (cmd.read) begin
         rd_exp_ff <= mem_exp[idx_ff];
         rd_rcv_ff <= mem_rcv[idx_ff];
         rd_vld_ff <= vld_ff[idx_ff];
      end
      if (cmd.calc1) begin
         expected_ff <= cycles_ff + {16'b0, maxs_ff} - {16'b0, bases_ff} + 32'd1;
         rcv_int_ff  <= recv_ff - prior_rcv;
         include_ff  <= (prior_rcv != recv_ff);
      end
      if (cmd.calc2) begin
         cum_ff     <= cum_in;
         frac_ok_ff <= (exp_int != '0) && !lost_int[31] && (lost_int != '0);
         divisor_ff <= exp_int;
         rem_ff     <= '0;
         quo_ff     <= {lost_int[23:0], 8'b0};
      end
      if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.finish && include_ff) begin
         mem_exp[idx_ff] <= expected_ff;
         mem_rcv[idx_ff] <= recv_ff;
      end
      if (cmd.finish) begin
         rsp_included        <= include_ff;
         rsp_ssrc_out        <= include_ff ? ssrc_ff : '0;
         rsp_fraction_lost   <= (include_ff && frac_ok_ff) ? quo_ff[7:0] : '0;
         rsp_cumulative_lost <= include_ff ? cum_ff : '0;
         rsp_highest_seq_ext <= include_ff ? (cycles_ff + {16'b0, maxs_ff}) : '0;
         rsp_jitter_out      <= include_ff ? jit_ff : '0;
         rsp_last_sr         <= include_ff ? last_sr_ff : '0;
         rsp_delay_last_sr   <= (include_ff && seen_ff) ? dly_ff : '0;
         rsp_total_lost      <= include_ff ? lost_sat : lost_base;
         rsp_total_received  <= include_ff ? rcv_sat : rcv_base;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         lost_sum_ff  <= '0;
         rcv_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            lost_sum_ff  <= include_ff ? lost_sat : lost_base;
            rcv_sum_ff   <= include_ff ? rcv_sat : rcv_base;
            if (include_ff) begin
               vld_ff[idx_ff] <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("result load did not raise valid");

   a_drop_on_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !cmd.finish) |=> !rsp_valid)
      else $error("result repeated after transfer");

   a_excluded_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !include_ff) |=>
         (rsp_fraction_lost == '0 && rsp_ssrc_out == '0 && rsp_cumulative_lost == '0))
      else $error("excluded source produced report fields");

endmodule

### hdl/rtcp_receiver_report_stats.sv
`timescale 1ns / 1ps
// From input transfer to result valid an item passes the table read, two arithmetic
// steps, 32 divider steps and the result load, which waits while the result register is full.
// Only one item is in work at a time, through the bit-serial 32-step loss-fraction divider.
// The next item is accepted while a finished result still waits in the output register.
// Reset (synchronous, active high) clears all prior-count table entries through their
// valid bits, zeroes the running totals and empties the output register at once.
// Top level of the RTCP receiver report statistics block.
module rtcp_receiver_report_stats #(
   parameter int SOURCES = rtcp_rr_pkg::SOURCES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rtcp_rr_pkg::SLOT_W-1:0]  req_slot,
   input  logic                            req_start_of_report,
   input  logic [31:0]                     req_source_id,
   input  logic [31:0]                     req_seq_cycles,
   input  logic [15:0]                     req_max_seq,
   input  logic [15:0]                     req_base_seq,
   input  logic [31:0]                     req_received_count,
   input  logic [31:0]                     req_jitter_in,
   input  logic [31:0]                     req_sr_ntp_seconds,
   input  logic [31:0]                     req_sr_ntp_fraction,
   input  logic                            req_sr_seen,
   input  logic [31:0]                     req_delay_since_sr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_included,
   output logic [31:0]                     rsp_ssrc_out,
   output logic [7:0]                      rsp_fraction_lost,
   output logic signed [23:0]              rsp_cumulative_lost,
   output logic [31:0]                     rsp_highest_seq_ext,
   output logic [31:0]                     rsp_jitter_out,
   output logic [31:0]                     rsp_last_sr,
   output logic [31:0]                     rsp_delay_last_sr,
   output logic signed [28:0]              rsp_total_lost,
   output logic [36:0]                     rsp_total_received
);
   import rtcp_rr_pkg::*;

   // Command and status between the sequencer and the datapath.
   cmd_type    cmd;
   status_type status;

   // Sequencer: take one transfer, step read / compute / divide, then hold
   // until the output register frees up and load the result.
   rtcp_rr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: prior counts per slot, interval math, divider, running
   // totals and the result register that drives the rsp_ channel.
   rtcp_rr_dp #(
      .SOURCES (SOURCES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_slot            (req_slot),
      .req_start_of_report (req_start_of_report),
      .req_source_id       (req_source_id),
      .req_seq_cycles      (req_seq_cycles),
      .req_max_seq         (req_max_seq),
      .req_base_seq        (req_base_seq),
      .req_received_count  (req_received_count),
      .req_jitter_in       (req_jitter_in),
      .req_sr_ntp_seconds  (req_sr_ntp_seconds),
      .req_sr_ntp_fraction (req_sr_ntp_fraction),
      .req_sr_seen         (req_sr_seen),
      .req_delay_since_sr  (req_delay_since_sr),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_included        (rsp_included),
      .rsp_ssrc_out        (rsp_ssrc_out),
      .rsp_fraction_lost   (rsp_fraction_lost),
      .rsp_cumulative_lost (rsp_cumulative_lost),
      .rsp_highest_seq_ext (rsp_highest_seq_ext),
      .rsp_jitter_out      (rsp_jitter_out),
      .rsp_last_sr         (rsp_last_sr),
      .rsp_delay_last_sr   (rsp_delay_last_sr),
      .rsp_total_lost      (rsp_total_lost),
      .rsp_total_received  (rsp_total_received)
   );

endmodule
